>>> rtl/cop_pkg.sv
// ----------------------------------------------------------------------------
// cop_pkg
// Shared widths, command codes, sequencer states and the request/response
// types of the iterative square-root / divide unit.
// ----------------------------------------------------------------------------
package cop_pkg;

  localparam int FRAC_BITS  = 8;
  // the limit truncates to 0, so only a distance of zero counts as zero
  localparam int NEAR_LIMIT = (1 << FRAC_BITS) / 10000;

  localparam int RAD_W   = 24;
  localparam int POS_W   = 32;
  localparam int DIFF_W  = POS_W + 1;
  localparam int SUM_W   = POS_W + 2;
  localparam int MAG_W   = RAD_W + 1;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int NUM_W   = PROD_W + 1;
  localparam int QUOT_W  = MAG_W + 1;
  localparam int REM_W   = MAG_W + 3;
  localparam int CNT_W   = 5;

  localparam int SQRT_STEPS = PROD_W / 2;
  localparam int DIV_STEPS  = QUOT_W;

  localparam logic [1:0] CMD_BEGIN    = 2'd0;
  localparam logic [1:0] CMD_OBSTACLE = 2'd1;
  localparam logic [1:0] CMD_FINISH   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_M,
    S_CMP,
    S_SQRT,
    S_MUL_X,
    S_GO_X,
    S_WAIT_X,
    S_MUL_Y,
    S_GO_Y,
    S_WAIT_Y,
    S_UPDATE
  } state_t;

  typedef enum logic {
    MODE_SQRT,
    MODE_DIV
  } iter_mode_t;

  typedef struct packed {
    logic               start;
    iter_mode_t         mode;
    logic [NUM_W-1:0]   operand;
    logic [MAG_W-1:0]   divisor;
  } iter_req_t;

  typedef struct packed {
    logic               done;
    logic [QUOT_W-1:0]  result;
  } iter_rsp_t;

endpackage

>>> rtl/cylinder_overlap_pushout.sv
// ----------------------------------------------------------------------------
// cylinder_overlap_pushout
// Pushes a body out of vertical cylinder obstacles presented in order.
//
//   channel | signals                                  | handshake
//   --------+------------------------------------------+----------------
//   cfg     | cfg_radius                               | cfg_valid/ready
//   in      | command, start_*, center_*, height/radius| in_valid/stall
//   out     | final_x, final_y, final_z                | out_valid/stall
//
// An obstacle that misses the height or box test returns to idle after the
// check, one that fails the squared-distance compare after the compare, and
// one that overlaps takes five passes through the shared multiplier, a
// 25-step square root and two 26-step divisions on the shared iterative
// unit (only three multiplier passes, no divisions, when the distance counts
// as zero). Reset clears position and radius to zero. in_stall is high while
// an obstacle is worked on, and for a finish while the last result waits.
// ----------------------------------------------------------------------------
module cylinder_overlap_pushout import cop_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [RAD_W-1:0]         cfg_radius,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               command,
  input  logic signed [POS_W-1:0]  start_x,
  input  logic signed [POS_W-1:0]  start_y,
  input  logic signed [POS_W-1:0]  start_z,
  input  logic signed [POS_W-1:0]  center_x,
  input  logic signed [POS_W-1:0]  center_y,
  input  logic signed [POS_W-1:0]  center_z,
  input  logic [RAD_W-1:0]         obstacle_height,
  input  logic [RAD_W-1:0]         obstacle_radius,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [POS_W-1:0]  final_x,
  output logic signed [POS_W-1:0]  final_y,
  output logic signed [POS_W-1:0]  final_z
);

  state_t                   state, state_next;
  logic [RAD_W-1:0]         radius_cfg;
  logic signed [POS_W-1:0]  run_x, run_y, run_z;
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic [RAD_W-1:0]         height;
  logic [MAG_W-1:0]         m;
  logic [MAG_W-1:0]         ax, ay;
  logic                     neg_x, neg_y;
  logic [NUM_W-1:0]         d2;
  logic [MAG_W-1:0]         hdist;
  logic [MAG_W-1:0]         ovl;
  logic [QUOT_W-1:0]        qx, qy;

  logic                     in_acc;
  logic                     mul_en;
  logic [MAG_W-1:0]         mul_a, mul_b;
  logic [PROD_W-1:0]        prod;
  iter_req_t                iter_req;
  iter_rsp_t                iter_rsp;

  logic [DIFF_W-1:0]        abs_x, abs_y, abs_z;
  logic                     miss;
  logic                     near;
  logic signed [SUM_W-1:0]  sum_x, sum_y;

  function automatic logic signed [POS_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic [2:0] top;
    top = v[SUM_W-1:POS_W-1];
    if (top == 3'b000 || top == 3'b111) begin
      return v[POS_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall && command == CMD_FINISH);
  assign in_acc    = in_valid && !in_stall;

  cop_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  cop_iter u_iter (
    .clk (clk),
    .rst (rst),
    .req (iter_req),
    .rsp (iter_rsp)
  );

  always_comb begin
    abs_x = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    abs_y = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    abs_z = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
    miss  = (abs_z > {{(DIFF_W-RAD_W){1'b0}}, height})
         || (abs_x >= {{(DIFF_W-MAG_W){1'b0}}, m})
         || (abs_y >= {{(DIFF_W-MAG_W){1'b0}}, m});
    near  = iter_rsp.result <= QUOT_W'(NEAR_LIMIT);
    sum_x = SUM_W'(run_x) + (neg_x ? -$signed(SUM_W'(qx)) : $signed(SUM_W'(qx)));
    sum_y = SUM_W'(run_y) + (neg_y ? -$signed(SUM_W'(qy)) : $signed(SUM_W'(qy)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    mul_en           = 1'b0;
    mul_a            = ax;
    mul_b            = ax;
    iter_req.start   = 1'b0;
    iter_req.mode    = MODE_SQRT;
    iter_req.operand = d2;
    iter_req.divisor = hdist;
    case (state)
      S_IDLE: begin
        if (in_acc && command == CMD_OBSTACLE) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = miss ? S_IDLE : S_SQ_X;
      end
      S_SQ_X: begin
        mul_en     = 1'b1;
        state_next = S_SQ_Y;
      end
      S_SQ_Y: begin
        mul_en     = 1'b1;
        mul_a      = ay;
        mul_b      = ay;
        state_next = S_SQ_M;
      end
      S_SQ_M: begin
        mul_en     = 1'b1;
        mul_a      = m;
        mul_b      = m;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (d2 >= {1'b0, prod}) begin
          state_next = S_IDLE;
        end else begin
          iter_req.start = 1'b1;
          state_next     = S_SQRT;
        end
      end
      S_SQRT: begin
        if (iter_rsp.done) begin
          state_next = near ? S_UPDATE : S_MUL_X;
        end
      end
      S_MUL_X: begin
        mul_en     = 1'b1;
        mul_b      = ovl;
        state_next = S_GO_X;
      end
      S_GO_X: begin
        iter_req.start   = 1'b1;
        iter_req.mode    = MODE_DIV;
        iter_req.operand = {1'b0, prod} + NUM_W'(hdist >> 1);
        state_next       = S_WAIT_X;
      end
      S_WAIT_X: begin
        if (iter_rsp.done) begin
          state_next = S_MUL_Y;
        end
      end
      S_MUL_Y: begin
        mul_en     = 1'b1;
        mul_a      = ay;
        mul_b      = ovl;
        state_next = S_GO_Y;
      end
      S_GO_Y: begin
        iter_req.start   = 1'b1;
        iter_req.mode    = MODE_DIV;
        iter_req.operand = {1'b0, prod} + NUM_W'(hdist >> 1);
        state_next       = S_WAIT_Y;
      end
      S_WAIT_Y: begin
        if (iter_rsp.done) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state: position, radius, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_cfg <= '0;
      run_x      <= '0;
      run_y      <= '0;
      run_z      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        radius_cfg <= cfg_radius;
      end
      if (in_acc && command == CMD_BEGIN) begin
        run_x <= start_x;
        run_y <= start_y;
        run_z <= start_z;
      end
      if (state == S_UPDATE) begin
        run_x <= sat(sum_x);
        run_y <= sat(sum_y);
      end
      if (in_acc && command == CMD_FINISH) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc && command == CMD_OBSTACLE) begin
      dx     <= DIFF_W'(run_x) - DIFF_W'(center_x);
      dy     <= DIFF_W'(run_y) - DIFF_W'(center_y);
      dz     <= DIFF_W'(run_z) - DIFF_W'(center_z);
      height <= obstacle_height;
      m      <= MAG_W'(radius_cfg) + MAG_W'(obstacle_radius);
    end
    if (in_acc && command == CMD_FINISH) begin
      final_x <= run_x;
      final_y <= run_y;
      final_z <= run_z;
    end
    case (state)
      S_CHECK: begin
        // only kept when below m, so the low bits carry the magnitude
        ax    <= abs_x[MAG_W-1:0];
        ay    <= abs_y[MAG_W-1:0];
        neg_x <= dx[DIFF_W-1];
        neg_y <= dy[DIFF_W-1];
      end
      // each product shows up in the cycle after the multiplier is fed
      S_SQ_Y: begin
        d2 <= {1'b0, prod};
      end
      S_SQ_M: begin
        d2 <= d2 + {1'b0, prod};
      end
      S_SQRT: begin
        if (iter_rsp.done) begin
          hdist <= iter_rsp.result[MAG_W-1:0];
          ovl   <= m - iter_rsp.result[MAG_W-1:0];
          if (near) begin
            qx    <= {1'b0, m - iter_rsp.result[MAG_W-1:0]};
            qy    <= '0;
            neg_x <= 1'b0;
          end
        end
      end
      S_WAIT_X: begin
        if (iter_rsp.done) begin
          qx <= iter_rsp.result;
        end
      end
      S_WAIT_Y: begin
        if (iter_rsp.done) begin
          qy <= iter_rsp.result;
        end
      end
      default: begin
      end
    endcase
  end

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    iter_rsp.done |-> (state == S_SQRT || state == S_WAIT_X || state == S_WAIT_Y))
    else $error("iterative unit finished with no one waiting");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && command == CMD_FINISH))
    else $error("result raised without a finish request");

  a_z_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && command != CMD_BEGIN) |=> $stable(run_z))
    else $error("z moved outside a begin request");

  a_check_after_obstacle: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> $past(in_valid && !in_stall && command == CMD_OBSTACLE))
    else $error("obstacle check entered without an obstacle request");

endmodule

>>> rtl/cop_mul.sv
// ----------------------------------------------------------------------------
// cop_mul
// Shared unsigned multiplier with a registered, enabled product.
// ----------------------------------------------------------------------------
module cop_mul import cop_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [MAG_W-1:0]  a,
  input  logic [MAG_W-1:0]  b,
  output logic [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

>>> rtl/cop_iter.sv
// ----------------------------------------------------------------------------
// cop_iter
// Iterative unit: integer square root (two bits per step) or restoring
// division (one bit per step), both on one compare-and-subtract.
// ----------------------------------------------------------------------------
module cop_iter import cop_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  iter_req_t req,
  output iter_rsp_t rsp
);

  logic                busy;
  logic                done;
  iter_mode_t          mode_r;
  logic [CNT_W-1:0]    cnt;
  logic [REM_W-1:0]    rem;
  logic [QUOT_W-1:0]   acc;
  logic [NUM_W-1:0]    src;
  logic [MAG_W-1:0]    dvs;

  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;
  logic [REM_W:0]      diff;
  logic                take;

  always_comb begin
    if (mode_r == MODE_SQRT) begin
      rem_sh = {rem[REM_W-3:0], src[PROD_W-1:PROD_W-2]};
      trial  = {acc[REM_W-3:0], 2'b01};
    end else begin
      rem_sh = {rem[REM_W-2:0], src[NUM_W-1]};
      trial  = {{(REM_W-MAG_W){1'b0}}, dvs};
    end
    diff = {1'b0, rem_sh} - {1'b0, trial};
    take = ~diff[REM_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        mode_r <= req.mode;
        cnt    <= (req.mode == MODE_SQRT) ? CNT_W'(SQRT_STEPS) : CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient is known to fit QUOT_W bits, so the top of the numerator
  // is already below the divisor and seeds the remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs <= req.divisor;
      acc <= '0;
      if (req.mode == MODE_SQRT) begin
        rem <= '0;
        src <= req.operand;
      end else begin
        rem <= {{(REM_W-MAG_W){1'b0}}, req.operand[NUM_W-1:QUOT_W]};
        src <= {req.operand[QUOT_W-1:0], {(NUM_W-QUOT_W){1'b0}}};
      end
    end else if (busy) begin
      rem <= take ? diff[REM_W-1:0] : rem_sh;
      acc <= {acc[QUOT_W-2:0], take};
      src <= (mode_r == MODE_SQRT) ? (src << 2) : (src << 1);
    end
  end

  assign rsp.done   = done;
  assign rsp.result = acc;

endmodule
